@@ rtl/core/tvps_pkg.sv @@
package tvps_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_e;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_ADD  = 1'b1;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DUR_W   = 16;

  localparam logic [DUR_W-1:0] MAX_DURATION_RESET = 16'd300;

  typedef struct packed {
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_end;
  } entry_t;

endpackage

@@ rtl/core/timed_valve_pump_scheduler.sv @@
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o  | req_type, now_time, level_ok, event_*
// out     | output    | out_valid_o / out_stall_i| valve_open, pump_on, watering, counts, flags
// cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_data_i = max_duration_s
//
// Add items and ticks in watering go straight to ST_DONE, then back to ST_IDLE.
// A tick in standby reads one table entry a cycle and, if it takes an event with
// the level OK, compacts the entries behind that event.
// Reset clears mode, count, run state and max_duration_s to 300; table is not cleared.
// in_stall_o is high while an item is in work; a finished result waits in the
// output register, and the next item may be accepted meanwhile.
module timed_valve_pump_scheduler #(
  parameter int unsigned MAX_EVENTS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic [tvps_pkg::TIME_W-1:0]         now_time_i,
  input  logic                                level_ok_i,
  input  logic [tvps_pkg::TIME_W-1:0]         event_start_i,
  input  logic [tvps_pkg::TIME_W-1:0]         event_end_i,
  input  logic                                event_valid_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                valve_open_o,
  output logic                                pump_on_o,
  output logic                                watering_o,
  output logic [$clog2(MAX_EVENTS + 1)-1:0]   pending_count_o,
  output logic                                level_fault_o,
  output logic                                add_dropped_o,

  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tvps_pkg::DUR_W-1:0]          cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(MAX_EVENTS + 1);
  localparam int unsigned IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int unsigned TW    = tvps_pkg::TIME_W;
  localparam int unsigned DW    = tvps_pkg::DUR_W;

  tvps_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]     count_q, count_d;
  logic                 mode_q, mode_d;
  logic [TW-1:0]        started_q, started_d;
  logic [TW-1:0]        run_end_q, run_end_d;
  logic                 has_event_q, has_event_d;
  logic [DW-1:0]        max_q, max_d;

  logic [TW-1:0]        now_q, now_d;
  logic                 lvl_q, lvl_d;
  logic                 fault_q, fault_d;
  logic                 drop_q, drop_d;

  logic [CNT_W-1:0]     scan_q, scan_d;
  logic                 chk_valid_q, chk_valid_d;
  logic [CNT_W-1:0]     chk_idx_q, chk_idx_d;
  logic [CNT_W-1:0]     sh_q, sh_d;
  logic                 wr_pend_q, wr_pend_d;
  logic [CNT_W-1:0]     wr_idx_q, wr_idx_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_mode_q, out_mode_d;
  logic [CNT_W-1:0]     out_cnt_q, out_cnt_d;
  logic                 out_fault_q, out_fault_d;
  logic                 out_drop_q, out_drop_d;

  tvps_pkg::entry_t     mem [MAX_EVENTS];
  tvps_pkg::entry_t     rdata_q;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  tvps_pkg::entry_t     mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;

  logic [TW:0]          limit;

  assign limit = {1'b0, started_q} + {{(TW + 1 - DW){1'b0}}, max_q};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    mode_d      = mode_q;
    started_d   = started_q;
    run_end_d   = run_end_q;
    has_event_d = has_event_q;
    max_d       = max_q;
    now_d       = now_q;
    lvl_d       = lvl_q;
    fault_d     = fault_q;
    drop_d      = drop_q;
    scan_d      = scan_q;
    chk_valid_d = chk_valid_q;
    chk_idx_d   = chk_idx_q;
    sh_d        = sh_q;
    wr_pend_d   = wr_pend_q;
    wr_idx_d    = wr_idx_q;
    out_mode_d  = out_mode_q;
    out_cnt_d   = out_cnt_q;
    out_fault_d = out_fault_q;
    out_drop_d  = out_drop_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;
    in_stall_o  = (state_q != tvps_pkg::ST_IDLE);
    cfg_ready_o = (state_q == tvps_pkg::ST_IDLE);

    if (cfg_valid_i && cfg_ready_o) begin
      max_d = cfg_data_i;
    end

    unique case (state_q)
      tvps_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          now_d   = now_time_i;
          lvl_d   = level_ok_i;
          fault_d = 1'b0;
          drop_d  = 1'b0;
          if (req_type_i == tvps_pkg::REQ_ADD) begin
            if (event_valid_i) begin
              if (count_q < CNT_W'(MAX_EVENTS)) begin
                mem_we    = 1'b1;
                mem_waddr = count_q[IDX_W-1:0];
                mem_wdata = '{t_start: event_start_i, t_end: event_end_i};
                count_d   = count_q + CNT_W'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            state_d = tvps_pkg::ST_DONE;
          end else if (mode_q) begin
            if (limit <= {1'b0, now_time_i}) begin
              mode_d = 1'b0;
            end else if (has_event_q && (run_end_q <= now_time_i)) begin
              has_event_d = 1'b0;
              mode_d      = 1'b0;
            end
            state_d = tvps_pkg::ST_DONE;
          end else begin
            scan_d      = '0;
            chk_valid_d = 1'b0;
            state_d     = tvps_pkg::ST_SCAN;
          end
        end
      end

      tvps_pkg::ST_SCAN: begin
        chk_valid_d = 1'b0;
        if (scan_q < count_q) begin
          mem_raddr   = scan_q[IDX_W-1:0];
          scan_d      = scan_q + CNT_W'(1);
          chk_valid_d = 1'b1;
          chk_idx_d   = scan_q;
        end
        if (chk_valid_q && (rdata_q.t_start <= now_q)) begin
          run_end_d   = rdata_q.t_end;
          has_event_d = 1'b1;
          chk_valid_d = 1'b0;
          if (!lvl_q) begin
            fault_d = 1'b1;
            state_d = tvps_pkg::ST_DONE;
          end else begin
            mode_d    = 1'b1;
            started_d = now_q;
            sh_d      = chk_idx_q + CNT_W'(1);
            wr_pend_d = 1'b0;
            state_d   = tvps_pkg::ST_SHIFT;
          end
        end else if (scan_q >= count_q) begin
          state_d = tvps_pkg::ST_DONE;
        end
      end

      tvps_pkg::ST_SHIFT: begin
        wr_pend_d = 1'b0;
        if (sh_q < count_q) begin
          mem_raddr = sh_q[IDX_W-1:0];
          sh_d      = sh_q + CNT_W'(1);
          wr_pend_d = 1'b1;
          wr_idx_d  = sh_q - CNT_W'(1);
        end
        if (wr_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_idx_q[IDX_W-1:0];
          mem_wdata = rdata_q;
        end
        if ((sh_q >= count_q) && !wr_pend_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = tvps_pkg::ST_DONE;
        end
      end

      tvps_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_mode_d  = mode_q;
          out_cnt_d   = count_q;
          out_fault_d = fault_q;
          out_drop_d  = drop_q;
          state_d     = tvps_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tvps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tvps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      mode_q      <= 1'b0;
      started_q   <= '0;
      run_end_q   <= '0;
      has_event_q <= 1'b0;
      max_q       <= tvps_pkg::MAX_DURATION_RESET;
      chk_valid_q <= 1'b0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      mode_q      <= mode_d;
      started_q   <= started_d;
      run_end_q   <= run_end_d;
      has_event_q <= has_event_d;
      max_q       <= max_d;
      chk_valid_q <= chk_valid_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    lvl_q       <= lvl_d;
    fault_q     <= fault_d;
    drop_q      <= drop_d;
    scan_q      <= scan_d;
    chk_idx_q   <= chk_idx_d;
    sh_q        <= sh_d;
    wr_idx_q    <= wr_idx_d;
    out_mode_q  <= out_mode_d;
    out_cnt_q   <= out_cnt_d;
    out_fault_q <= out_fault_d;
    out_drop_q  <= out_drop_d;
  end

  // event table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign out_valid_o     = out_valid_q;
  assign valve_open_o    = out_mode_q;
  assign pump_on_o       = out_mode_q;
  assign watering_o      = out_mode_q;
  assign pending_count_o = out_cnt_q;
  assign level_fault_o   = out_fault_q;
  assign add_dropped_o   = out_drop_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_EVENTS))
    else $error("pending count above table depth");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mode_q) |-> $past(state_q) == tvps_pkg::ST_SCAN)
    else $error("watering entered outside table scan");

  a_count_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q < $past(count_q)) |-> $past(state_q) == tvps_pkg::ST_SHIFT)
    else $error("pending count dropped outside compaction");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == tvps_pkg::ST_DONE)
    else $error("result transaction raised without finished item");

  a_shift_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tvps_pkg::ST_SHIFT && wr_pend_q) |->
      ({1'b0, wr_idx_q} + (CNT_W + 1)'(1) < {1'b0, count_q}))
    else $error("compaction write outside live entries");

endmodule

@@ tb/timed_valve_pump_scheduler_test.sv @@
module timed_valve_pump_scheduler_test;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    bit       valve_open;
    bit       pump_on;
    bit       watering;
    bit [4:0] pending_count;
    bit       level_fault;
    bit       add_dropped;
  } status_t;

  class schedule_tracker;
    bit [31:0]   ev_start [DEPTH];
    bit [31:0]   ev_end [DEPTH];
    bit [4:0]    total;
    bit          watering;
    bit [31:0]   run_started;
    bit [31:0]   run_end;
    bit          run_has_event;
    bit [15:0]   max_dur;
    status_t     expected_status[$];
    int unsigned errors;

    function new();
      total = 0;
      watering = 0;
      run_started = 0;
      run_end = 0;
      run_has_event = 0;
      max_dur = tvps_pkg::MAX_DURATION_RESET;
      errors = 0;
    endfunction

    function void set_max_duration(bit [15:0] v);
      max_dur = v;
    endfunction

    function int outstanding();
      return expected_status.size();
    endfunction

    function void note_request(bit req, bit [31:0] now, bit lvl, bit [31:0] es,
                               bit [31:0] ee, bit ev);
      status_t   st;
      bit        fault;
      bit        dropped;
      bit [32:0] limit;
      int        hit;
      fault = 0;
      dropped = 0;
      hit = -1;
      if (req == tvps_pkg::REQ_ADD) begin
        if (ev) begin
          if (total < DEPTH) begin
            ev_start[total[3:0]] = es;
            ev_end[total[3:0]] = ee;
            total++;
          end else begin
            dropped = 1;
          end
        end
      end else if (!watering) begin
        for (int i = 0; i < total && hit < 0; i++) begin
          if (ev_start[i] <= now) hit = i;
        end
        if (hit >= 0) begin
          run_end = ev_end[hit];
          run_has_event = 1;
          if (!lvl) begin
            fault = 1;
          end else begin
            watering = 1;
            run_started = now;
            for (int j = hit; j < total - 1; j++) begin
              ev_start[j] = ev_start[j+1];
              ev_end[j] = ev_end[j+1];
            end
            total--;
          end
        end
      end else begin
        // 33-bit sum so a run started near the top of time does not wrap
        limit = {1'b0, run_started} + {17'd0, max_dur};
        if (limit <= {1'b0, now}) begin
          watering = 0;
        end else if (run_has_event && run_end <= now) begin
          run_has_event = 0;
          watering = 0;
        end
      end
      st.valve_open = watering;
      st.pump_on = watering;
      st.watering = watering;
      st.pending_count = total;
      st.level_fault = fault;
      st.add_dropped = dropped;
      expected_status = {expected_status, st};
    endfunction

    function void compare(string field, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_status(bit valve, bit pump, bit wat, bit [4:0] cnt, bit fault,
                               bit dropped);
      status_t st;
      if (expected_status.size() == 0) begin
        $error("status transaction with nothing outstanding");
        errors++;
        return;
      end
      st = expected_status.pop_front();
      compare("valve_open", st.valve_open, valve);
      compare("pump_on", st.pump_on, pump);
      compare("watering", st.watering, wat);
      compare("pending_count", st.pending_count, cnt);
      compare("level_fault", st.level_fault, fault);
      compare("add_dropped", st.add_dropped, dropped);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = 1'b0;
  logic [31:0] now_time_i = '0;
  logic        level_ok_i = 1'b0;
  logic [31:0] event_start_i = '0;
  logic [31:0] event_end_i = '0;
  logic        event_valid_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        valve_open_o;
  logic        pump_on_o;
  logic        watering_o;
  logic [4:0]  pending_count_o;
  logic        level_fault_o;
  logic        add_dropped_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  schedule_tracker sched;
  int          cycles = 0;
  int          issued = 0;
  int          burst_left = 0;
  int          stall_style = 0;
  int          stall_hold = 0;
  bit [31:0]   cur_time = 0;

  timed_valve_pump_scheduler #(.MAX_EVENTS(DEPTH)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .now_time_i      (now_time_i),
    .level_ok_i      (level_ok_i),
    .event_start_i   (event_start_i),
    .event_end_i     (event_end_i),
    .event_valid_i   (event_valid_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .valve_open_o    (valve_open_o),
    .pump_on_o       (pump_on_o),
    .watering_o      (watering_o),
    .pending_count_o (pending_count_o),
    .level_fault_o   (level_fault_o),
    .add_dropped_o   (add_dropped_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timed_valve_pump_scheduler: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sched.note_request(req_type_i, now_time_i, level_ok_i, event_start_i, event_end_i,
                         event_valid_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sched.check_status(valve_open_o, pump_on_o, watering_o, pending_count_o,
                         level_fault_o, add_dropped_o);
    end
  end

  // receiver: switches between no stall, light stall and heavy stall
  always @(posedge clk_i) begin
    if (stall_hold == 0) begin
      stall_style <= $urandom_range(0, 2);
      stall_hold <= $urandom_range(50, 400);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_style)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic issue(bit req, bit [31:0] now, bit lvl, bit [31:0] es, bit [31:0] ee,
                       bit ev);
    in_valid_i <= 1'b1;
    req_type_i <= req;
    now_time_i <= now;
    level_ok_i <= lvl;
    event_start_i <= es;
    event_end_i <= ee;
    event_valid_i <= ev;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (!(req == tvps_pkg::REQ_ADD && !ev)) issued++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  task automatic tick(bit [31:0] now, bit lvl);
    issue(tvps_pkg::REQ_TICK, now, lvl, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
  endtask

  task automatic add_event(bit [31:0] es, bit [31:0] ee);
    issue(tvps_pkg::REQ_ADD, $urandom(), 1'($urandom_range(0, 1)), es, ee, 1'b1);
  endtask

  // hold off until every outstanding status has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sched.outstanding() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_max_duration(bit [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sched.set_max_duration(v);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(int target);
    int        goal;
    bit [31:0] s;
    goal = issued + target;
    while (issued < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          repeat ($urandom_range(1, 4)) begin
            s = cur_time + $urandom_range(0, 40);
            add_event(s, ($urandom_range(0, 7) == 0) ? s - $urandom_range(1, 100)
                                                     : s + $urandom_range(0, 60));
          end
          repeat ($urandom_range(3, 15)) begin
            cur_time += ($urandom_range(0, 15) == 0) ? $urandom_range(0, 70000)
                                                     : $urandom_range(0, 20);
            tick(cur_time, $urandom_range(0, 9) != 0);
          end
        end
        5: begin
          repeat ($urandom_range(16, 20)) begin
            s = cur_time + $urandom_range(0, 500);
            add_event(s, s + $urandom_range(0, 200));
          end
        end
        6: begin
          repeat ($urandom_range(2, 6)) begin
            issue(1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)), $urandom(),
                  $urandom(), 1'($urandom_range(0, 1)));
          end
        end
        7: begin
          // every start is due at the top of time; each pair of ticks empties one slot
          repeat ($urandom_range(4, 34)) tick(32'hFFFF_FFFF, 1'b1);
          cur_time = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1000) : $urandom();
        end
        8: begin
          cur_time = $urandom();
          tick(cur_time, 1'($urandom_range(0, 1)));
        end
        default: begin
          repeat ($urandom_range(2, 5)) tick(cur_time, 1'($urandom_range(0, 1)));
        end
      endcase
    end
  endtask

  initial begin
    bit [15:0] durations [5];
    sched = new();
    durations[0] = 16'd1;
    durations[1] = 16'hFFFF;
    durations[2] = 16'd300;
    durations[3] = 16'($urandom_range(2, 200));
    durations[4] = 16'($urandom_range(1, 65535));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tick(32'd0, 1'b1);
    issue(tvps_pkg::REQ_ADD, $urandom(), 1'b1, $urandom(), $urandom(), 1'b0);
    add_event(32'd0, 32'hFFFF_FFFF);
    tick(32'd0, 1'b0);
    tick(32'd0, 1'b1);
    add_event(32'd100, 32'd150);
    add_event(32'hFFFF_FF00, 32'hFFFF_FFF0);
    add_event(32'd0, 32'd10);
    tick(32'd299, 1'b1);
    tick(32'd300, 1'b1);
    tick(32'd120, 1'b1);
    tick(32'd150, 1'b1);
    tick(32'd151, 1'b1);
    tick(32'd152, 1'b1);
    tick(32'hFFFF_FF00, 1'b1);
    tick(32'hFFFF_FFE0, 1'b1);
    tick(32'hFFFF_FFF0, 1'b1);

    for (int p = 0; p < 5; p++) begin
      settle();
      write_max_duration(durations[p]);
      run_phase(290);
    end
    settle();

    if (sched.errors == 0 && sched.outstanding() == 0) begin
      $display("timed_valve_pump_scheduler: match");
    end else begin
      $display("timed_valve_pump_scheduler: mismatch");
    end
    $finish;
  end

endmodule
